@@ rtl/histogram_stretch_8bit_defines.svh @@
// assertion macros for the histogram stretch block
// used by hs8_unit and histogram_stretch_8bit; expects i_clk and i_rst_n in scope
`ifndef HISTOGRAM_STRETCH_8BIT_DEFINES_SVH
`define HISTOGRAM_STRETCH_8BIT_DEFINES_SVH

`ifndef SYNTHESIS

// checked only out of reset
`define HS8_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// checked on every edge, reset included
`define HS8_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`else

`define HS8_ASSERT(label, prop, msg)
`define HS8_ASSERT_ALWAYS(label, prop, msg)

`endif

`endif

@@ rtl/hs8_pkg.sv @@
// types, codes and constants shared by the histogram stretch block
// no dependencies
package hs8_pkg;

    localparam logic [7:0] FULL_SCALE = 8'd255;
    localparam int         STEPS      = 8;
    localparam int         CNT_W      = $clog2(STEPS);

    // pixel kinds
    localparam logic KIND_GATHER  = 1'b0;
    localparam logic KIND_STRETCH = 1'b1;

    // shared unit operations
    localparam logic OP_DIV = 1'b0;
    localparam logic OP_MUL = 1'b1;

    typedef struct packed {
        logic       kind;
        logic [7:0] pixel;
        logic       last;
    } t_in;

    typedef struct packed {
        logic [7:0] stretched;
        logic       last_out;
        logic       flat_frame;
    } t_out;

    typedef struct packed {
        logic       start;
        logic       op;
        logic [7:0] a;
        logic [7:0] b;
    } t_unit_cmd;

    typedef struct packed {
        logic       done;
        logic [7:0] result;
    } t_unit_rsp;

endpackage

@@ rtl/histogram_stretch_8bit.sv @@
// two-pass 8-bit contrast stretch: gather min/max, then stretch each pixel
// depends on hs8_pkg, hs8_unit and histogram_stretch_8bit_defines.svh
//
// input channel i_in_valid/o_in_ready carries one pixel word (kind, pixel, last).
// a gather word updates the running min and max and gives no result.
// the gather word marked last also works out gain = 255/(max-min) on the shared
// add/subtract unit, one quotient bit a cycle, with o_in_ready low until it ends.
// a flat frame (max equal to min) gives gain 0 and sets the flat flag at once.
// a stretch word runs (pixel-min)*gain on the same unit, one multiplier bit a
// cycle; o_out_valid rises together with o_in_ready as the product enters the
// output register, and the next word can be taken as soon as o_in_ready is high.
// sustained rate: one gather word per cycle; a stretch word or closing gather
// word holds off the next word until the 8 iterations of the shared unit end.
// output channel o_out_valid/i_out_ready holds one result word in a register; a
// stalled receiver holds it there, and a finished product waits in the block
// until the register frees up, with o_in_ready low meanwhile.
// synchronous reset gives min 255, max 0, gain 0, no flat flag, no open frame,
// and an empty output register.
`include "histogram_stretch_8bit_defines.svh"

module histogram_stretch_8bit
    import hs8_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_in  i_in,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_out o_out
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_DIV  = 2'd1;
    localparam logic [1:0] S_MUL  = 2'd2;
    localparam logic [1:0] S_HOLD = 2'd3;

    logic [1:0] r_state, n_state;
    logic [7:0] r_min, n_min;
    logic [7:0] r_max, n_max;
    logic [7:0] r_gain, n_gain;
    logic       r_open, n_open;
    logic       r_flat, n_flat;
    logic       r_last, n_last;
    logic [7:0] r_res, n_res;
    logic       r_out_valid, n_out_valid;
    t_out       r_out, n_out;

    logic       w_in_acc;
    logic       w_out_free;
    logic [7:0] w_base_min;
    logic [7:0] w_base_max;
    logic [7:0] w_new_min;
    logic [7:0] w_new_max;
    logic [7:0] w_diff;

    t_unit_cmd w_cmd;
    t_unit_rsp w_rsp;

    assign o_in_ready  = (r_state == S_IDLE);
    assign w_in_acc    = i_in_valid && o_in_ready;
    assign w_out_free  = !r_out_valid || i_out_ready;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // a gather word with no frame open restarts the statistics
    assign w_base_min = r_open ? r_min : FULL_SCALE;
    assign w_base_max = r_open ? r_max : 8'd0;
    assign w_new_min  = (i_in.pixel < w_base_min) ? i_in.pixel : w_base_min;
    assign w_new_max  = (i_in.pixel > w_base_max) ? i_in.pixel : w_base_max;
    assign w_diff     = (i_in.pixel > r_min) ? (i_in.pixel - r_min) : 8'd0;

    always_comb begin
        w_cmd.start = 1'b0;
        if (w_in_acc) begin
            if (i_in.kind == KIND_STRETCH) begin
                w_cmd.start = 1'b1;
            end else begin
                w_cmd.start = i_in.last && (w_new_max > w_new_min);
            end
        end
        if (i_in.kind == KIND_STRETCH) begin
            w_cmd.op = OP_MUL;
            w_cmd.a  = w_diff;
            w_cmd.b  = r_gain;
        end else begin
            w_cmd.op = OP_DIV;
            w_cmd.a  = w_new_max - w_new_min;
            w_cmd.b  = 8'd0;
        end
    end

    hs8_unit u_unit (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_cmd),
        .o_rsp   (w_rsp)
    );

    always_comb begin
        n_state     = r_state;
        n_min       = r_min;
        n_max       = r_max;
        n_gain      = r_gain;
        n_open      = r_open;
        n_flat      = r_flat;
        n_last      = r_last;
        n_res       = r_res;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out       = r_out;
        case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    if (i_in.kind == KIND_GATHER) begin
                        n_min = w_new_min;
                        n_max = w_new_max;
                        if (i_in.last) begin
                            n_open = 1'b0;
                            if (w_new_max > w_new_min) begin
                                n_state = S_DIV;
                            end else begin
                                n_gain = 8'd0;
                                n_flat = 1'b1;
                            end
                        end else begin
                            n_open = 1'b1;
                        end
                    end else begin
                        n_last  = i_in.last;
                        n_state = S_MUL;
                    end
                end
            end
            S_DIV: begin
                if (w_rsp.done) begin
                    n_gain  = w_rsp.result;
                    n_flat  = 1'b0;
                    n_state = S_IDLE;
                end
            end
            S_MUL: begin
                if (w_rsp.done) begin
                    if (w_out_free) begin
                        n_out_valid = 1'b1;
                        n_out       = '{stretched: w_rsp.result, last_out: r_last,
                                        flat_frame: r_flat};
                        n_state     = S_IDLE;
                    end else begin
                        n_res   = w_rsp.result;
                        n_state = S_HOLD;
                    end
                end
            end
            S_HOLD: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out       = '{stretched: r_res, last_out: r_last, flat_frame: r_flat};
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_min       <= FULL_SCALE;
            r_max       <= 8'd0;
            r_gain      <= 8'd0;
            r_open      <= 1'b0;
            r_flat      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_min       <= n_min;
            r_max       <= n_max;
            r_gain      <= n_gain;
            r_open      <= n_open;
            r_flat      <= n_flat;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_last <= n_last;
        r_res  <= n_res;
        r_out  <= n_out;
    end

    `HS8_ASSERT(a_done_when_waiting,
        w_rsp.done |-> (r_state == S_DIV || r_state == S_MUL),
        "unit result with nobody waiting")
    `HS8_ASSERT(a_stretch_runs,
        (w_in_acc && i_in.kind == KIND_STRETCH) |=> (r_state == S_MUL),
        "stretch word not sent to unit")
    `HS8_ASSERT(a_flat_gain, r_flat |-> (r_gain == 8'd0), "flat frame with non-zero gain")
    `HS8_ASSERT(a_open_order, r_open |-> (r_min <= r_max), "open frame with min above max")
    `HS8_ASSERT_ALWAYS(a_reset_empty, !i_rst_n |=> !o_out_valid,
        "output word valid after reset")

endmodule

@@ rtl/hs8_unit.sv @@
// shared add/subtract unit: restoring divide of full scale by a, or shift-add a*b
// depends on hs8_pkg and histogram_stretch_8bit_defines.svh
`include "histogram_stretch_8bit_defines.svh"

module hs8_unit
    import hs8_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_unit_cmd i_cmd,
    output t_unit_rsp o_rsp
);

    logic             r_busy;
    logic             r_done;
    logic             r_op;
    logic [CNT_W-1:0] r_cnt;
    logic [7:0]       r_a;
    logic [7:0]       r_b;
    logic [15:0]      r_acc;
    logic [7:0]       r_rem;
    logic [7:0]       r_q;

    logic [15:0] w_x;
    logic [15:0] w_y;
    logic        w_cin;
    logic [16:0] w_sum;
    logic [8:0]  w_rs;

    // dividend is all ones, so every step shifts in a one
    assign w_rs = {r_rem, 1'b1};

    always_comb begin
        if (r_op == OP_DIV) begin
            w_x   = {7'd0, w_rs};
            w_y   = ~{8'd0, r_a};
            w_cin = 1'b1;
        end else begin
            w_x   = {r_acc[14:0], 1'b0};
            w_y   = r_b[7] ? {8'd0, r_a} : 16'd0;
            w_cin = 1'b0;
        end
    end

    assign w_sum = {1'b0, w_x} + {1'b0, w_y} + {16'd0, w_cin};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_cmd.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_op  <= i_cmd.op;
            r_a   <= i_cmd.a;
            r_b   <= i_cmd.b;
            r_acc <= '0;
            r_rem <= '0;
            r_q   <= '0;
        end else if (r_busy) begin
            if (r_op == OP_DIV) begin
                // carry out means no borrow: the divisor fits
                if (w_sum[16]) begin
                    r_rem <= w_sum[7:0];
                    r_q   <= {r_q[6:0], 1'b1};
                end else begin
                    r_rem <= w_rs[7:0];
                    r_q   <= {r_q[6:0], 1'b0};
                end
            end else begin
                r_acc <= w_sum[15:0];
                r_b   <= {r_b[6:0], 1'b0};
            end
        end
    end

    always_comb begin
        o_rsp.done = r_done;
        if (r_op == OP_DIV) begin
            o_rsp.result = r_q;
        end else begin
            o_rsp.result = (r_acc[15:8] != 8'd0) ? FULL_SCALE : r_acc[7:0];
        end
    end

    `HS8_ASSERT(a_start_idle, i_cmd.start |-> !r_busy, "unit started while busy")
    `HS8_ASSERT(a_done_after_busy, r_done |-> (!r_busy && $past(r_busy)), "done without a run")
    `HS8_ASSERT(a_quot_nonzero, (r_done && r_op == OP_DIV) |-> (r_q != 8'd0), "zero gain from divide")

endmodule
